FILE: rtl/core/mtap_pkg.sv
// Types, codes and key character tables for the multi-tap text entry block.
`timescale 1ns / 1ps

package mtap_pkg;

    localparam int TEXT_MAX   = 31;
    localparam int LEN_W      = 5;
    localparam int KEY_N      = 9;
    localparam int KEY_SLOTS  = 10;
    localparam int CFG_ADDR_W = 3;

    localparam logic [5:0]  CAP_RESET     = 6'd32;
    localparam logic [5:0]  CAP_LIMIT     = 6'(TEXT_MAX + 1);
    localparam logic [15:0] TIMEOUT_RESET = 16'd800;
    localparam logic [7:0]  CONT_MASK     = 8'hC0;
    localparam logic [7:0]  CONT_TAG      = 8'h80;
    localparam logic [3:0]  KEY_LAST      = 4'(KEY_N - 1);

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_TIMEOUT  = 1'b1;

    typedef enum logic [1:0] {
        FN_PRESS = 2'd0,
        FN_ERASE = 2'd1,
        FN_LOAD  = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_ERASED   = 3'd2,
        ST_REFUSED  = 3'd3,
        ST_LOADED   = 3'd4,
        ST_READ     = 3'd5
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [3:0]  key;
        logic [31:0] now_ms;
        logic [7:0]  load_byte;
        logic [4:0]  read_index;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [4:0] text_length;
        logic [4:0] byte_pos;
        logic [7:0] byte_value;
    } t_out_item;

    localparam logic [7:0] KEY_LIST [KEY_N][KEY_SLOTS] = '{
        '{"0", "1", ",", "@", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"2", "!", "A", "B", "C", "a", "b", "c", 8'h00, 8'h00},
        '{"3", "@", "D", "E", "F", "d", "e", "f", 8'h00, 8'h00},
        '{"4", "#", "G", "H", "I", "g", "h", "i", 8'h00, 8'h00},
        '{"5", "$", "J", "K", "L", "j", "k", "l", 8'h00, 8'h00},
        '{"6", "%", "M", "N", "O", "m", "n", "o", 8'h00, 8'h00},
        '{"7", "^", "P", "Q", "R", "S", "p", "q", "r", "s"},
        '{"8", "&", "T", "U", "V", "t", "u", "v", 8'h00, 8'h00},
        '{"9", "*", "W", "X", "Y", "Z", "w", "x", "y", "z"}
    };

    localparam logic [3:0] KEY_SPAN [KEY_N] = '{
        4'd5, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd10, 4'd8, 4'd10
    };

endpackage

FILE: rtl/core/multitap_keypad_text_entry.sv
// Multi-tap keypad text entry: byte buffer in a synchronous memory with a sequencer.
// Press, load and refused items pass from input transfer through the decode and emit states to the result.
// Read adds a state for the registered memory read before emit.
// Erase adds a walk state that examines one byte per step while walking back over continuation bytes.
// One item in flight: the input stalls until the sequencer returns to idle with the result in the output register.
// Synchronous reset clears length, last key, time and registers; buffer contents are kept.
`timescale 1ns / 1ps

module multitap_keypad_text_entry
    import mtap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_RDATA,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    t_in_item         r_item, n_item;
    t_out_item        r_res, n_res;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [LEN_W-1:0] r_text_len, n_text_len;
    logic             r_prev_valid, n_prev_valid;
    logic [3:0]       r_prev_key, n_prev_key;
    logic [31:0]      r_prev_time, n_prev_time;
    logic [3:0]       r_cycle_pos, n_cycle_pos;
    logic [5:0]       r_capacity, n_capacity;
    logic [15:0]      r_timeout, n_timeout;
    logic             r_rd_hit, n_rd_hit;

    logic [7:0]       text_mem [TEXT_MAX+1];
    logic [7:0]       r_rdata;
    logic             mem_we, mem_re;
    logic [LEN_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata;

    logic             cfg_wr;
    logic [5:0]       cap_eff;
    logic             room;
    logic             key_ok;
    logic [3:0]       key_idx;
    logic [31:0]      gap;
    logic             press_cont;
    logic [3:0]       cycle_inc;
    logic [3:0]       next_cycle;
    logic [LEN_W-1:0] len_dec;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign prdata     = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout} : {26'd0, r_capacity};
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cap_eff    = (r_capacity > CAP_LIMIT) ? CAP_LIMIT : r_capacity;
    assign room       = ({1'b0, r_text_len} + 6'd1) < cap_eff;
    assign key_ok     = (r_item.key <= KEY_LAST);
    assign key_idx    = key_ok ? r_item.key : 4'd0;
    assign gap        = r_item.now_ms - r_prev_time;
    assign press_cont = r_prev_valid && (r_prev_key == r_item.key) && (r_text_len != '0) &&
                        (gap <= {16'd0, r_timeout});
    assign cycle_inc  = r_cycle_pos + 4'd1;
    assign next_cycle = (cycle_inc >= KEY_SPAN[key_idx]) ? 4'd0 : cycle_inc;
    assign len_dec    = r_text_len - LEN_W'(1);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_text_len   = r_text_len;
        n_prev_valid = r_prev_valid;
        n_prev_key   = r_prev_key;
        n_prev_time  = r_prev_time;
        n_cycle_pos  = r_cycle_pos;
        n_capacity   = r_capacity;
        n_timeout    = r_timeout;
        n_rd_hit     = r_rd_hit;
        mem_we       = 1'b0;
        mem_waddr    = r_text_len;
        mem_wdata    = KEY_LIST[key_idx][0];
        mem_re       = 1'b0;
        mem_raddr    = r_text_len;

        if (cfg_wr) begin
            if (paddr[2] == REG_TIMEOUT) begin
                n_timeout = pwdata[15:0];
            end else begin
                n_capacity = pwdata[5:0];
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                n_res   = '{status: ST_REFUSED, text_length: r_text_len,
                            byte_pos: '0, byte_value: '0};
                case (r_item.func)
                    FN_PRESS: begin
                        if (key_ok && press_cont) begin
                            mem_we           = 1'b1;
                            mem_waddr        = len_dec;
                            mem_wdata        = KEY_LIST[key_idx][next_cycle];
                            n_cycle_pos      = next_cycle;
                            n_prev_time      = r_item.now_ms;
                            n_res.status     = ST_REPLACED;
                            n_res.byte_pos   = len_dec;
                            n_res.byte_value = KEY_LIST[key_idx][next_cycle];
                        end else if (key_ok && room) begin
                            mem_we            = 1'b1;
                            n_cycle_pos       = 4'd0;
                            n_text_len        = r_text_len + LEN_W'(1);
                            n_prev_valid      = 1'b1;
                            n_prev_key        = r_item.key;
                            n_prev_time       = r_item.now_ms;
                            n_res.status      = ST_APPENDED;
                            n_res.text_length = r_text_len + LEN_W'(1);
                            n_res.byte_pos    = r_text_len;
                            n_res.byte_value  = KEY_LIST[key_idx][0];
                        end
                    end
                    FN_ERASE: begin
                        if (r_text_len != '0) begin
                            n_text_len        = len_dec;
                            n_prev_valid      = 1'b0;
                            n_prev_time       = '0;
                            n_res.status      = ST_ERASED;
                            n_res.text_length = len_dec;
                            n_res.byte_pos    = len_dec;
                            if (len_dec != '0) begin
                                mem_re    = 1'b1;
                                mem_raddr = len_dec;
                                n_state   = S_WALK;
                            end
                        end
                    end
                    FN_LOAD: begin
                        if (room) begin
                            mem_we            = 1'b1;
                            mem_wdata         = r_item.load_byte;
                            n_text_len        = r_text_len + LEN_W'(1);
                            n_prev_valid      = 1'b0;
                            n_prev_time       = '0;
                            n_res.status      = ST_LOADED;
                            n_res.text_length = r_text_len + LEN_W'(1);
                            n_res.byte_pos    = r_text_len;
                            n_res.byte_value  = r_item.load_byte;
                        end
                    end
                    FN_READ: begin
                        mem_re         = 1'b1;
                        mem_raddr      = r_item.read_index;
                        n_rd_hit       = (r_item.read_index < r_text_len);
                        n_res.status   = ST_READ;
                        n_res.byte_pos = r_item.read_index;
                        n_state        = S_RDATA;
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                if ((r_rdata & CONT_MASK) == CONT_TAG) begin
                    n_text_len        = len_dec;
                    n_res.text_length = len_dec;
                    n_res.byte_pos    = len_dec;
                    if (len_dec != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = len_dec;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_RDATA: begin
                n_res.byte_value = r_rd_hit ? r_rdata : 8'd0;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            text_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= text_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_text_len   <= '0;
            r_prev_valid <= 1'b0;
            r_prev_key   <= '0;
            r_prev_time  <= '0;
            r_cycle_pos  <= '0;
            r_capacity   <= CAP_RESET;
            r_timeout    <= TIMEOUT_RESET;
            r_rd_hit     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_text_len   <= n_text_len;
            r_prev_valid <= n_prev_valid;
            r_prev_key   <= n_prev_key;
            r_prev_time  <= n_prev_time;
            r_cycle_pos  <= n_cycle_pos;
            r_capacity   <= n_capacity;
            r_timeout    <= n_timeout;
            r_rd_hit     <= n_rd_hit;
        end
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECODE))
        else $error("transfer in not followed by decode");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_text_len != '0))
        else $error("continuation walk on empty text");

    a_cycle_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_valid |-> ((r_prev_key <= KEY_LAST) && (r_cycle_pos < KEY_SPAN[r_prev_key])))
        else $error("cycle position outside key list");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && !(r_out_valid && i_out_stall)) |=>
            (o_out_valid && (r_state == S_IDLE)))
        else $error("result not moved to output register");

endmodule
